// ===== src/extended_gcd_bezout_unit_assert.svh =====
// Assertion macros used by the checker file.
`ifndef EXTENDED_GCD_BEZOUT_UNIT_ASSERT_SVH
`define EXTENDED_GCD_BEZOUT_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EGB_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("extended gcd unit: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define EGB_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("extended gcd unit: assertion failed");

`endif

// ===== src/egb_pkg.sv =====
`default_nettype none

package egb_pkg;

  localparam int OPERAND_BITS_DEFAULT = 31;
  localparam int DIVISOR_BITS = 31;
  localparam int COEF_BITS = 32;
  localparam int PC_BITS = 3;

  typedef logic [PC_BITS-1:0] pc_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_UPDATE,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_REM_ZERO,
    COND_COUNT_NZ,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ucode_t;

  localparam pc_t STEP_IDLE     = 3'd0;
  localparam pc_t STEP_TEST     = 3'd1;
  localparam pc_t STEP_DIV_INIT = 3'd2;
  localparam pc_t STEP_DIV_STEP = 3'd3;
  localparam pc_t STEP_UPDATE   = 3'd4;
  localparam pc_t STEP_WAIT_OUT = 3'd5;
  localparam pc_t STEP_EMIT     = 3'd6;

  // A step whose condition holds jumps to its target, otherwise it falls through.
  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    unique case (pc)
      STEP_IDLE:     w = '{op: OP_LOAD,     cond: COND_NO_INPUT, target: STEP_IDLE};
      STEP_TEST:     w = '{op: OP_NONE,     cond: COND_REM_ZERO, target: STEP_WAIT_OUT};
      STEP_DIV_INIT: w = '{op: OP_DIV_INIT, cond: COND_NEVER,    target: STEP_IDLE};
      STEP_DIV_STEP: w = '{op: OP_DIV_STEP, cond: COND_COUNT_NZ, target: STEP_DIV_STEP};
      STEP_UPDATE:   w = '{op: OP_UPDATE,   cond: COND_ALWAYS,   target: STEP_TEST};
      STEP_WAIT_OUT: w = '{op: OP_NONE,     cond: COND_OUT_BUSY, target: STEP_WAIT_OUT};
      STEP_EMIT:     w = '{op: OP_EMIT,     cond: COND_ALWAYS,   target: STEP_IDLE};
      default:       w = '{op: OP_NONE,     cond: COND_ALWAYS,   target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== src/extended_gcd_bezout_unit.sv =====
// Extended Euclidean unit: returns gcd(a, b) and Bezout coefficients x, y
// with a*x + b*y = gcd.
// Input channel: in_valid, in_stall, first_operand, second_operand. A transfer
// takes place when in_valid is high and in_stall is low; in_stall is low only
// while the unit is idle, so one pair is worked on at a time.
// Output channel: out_valid, out_stall, divisor, coef_first, coef_second. The
// result sits in an output register and holds while out_stall is high; a new
// pair may be taken in meanwhile.
// Each Euclid division step runs a radix-2 restoring divider on the one shared
// datapath, with the quotient times coefficient products formed bit by bit
// alongside. The next pair can be taken in the cycle after the result is loaded.
// If out_stall still holds the previous result, the unit waits for its
// transfer before loading the new one.
// Reset returns the sequencer to its idle step and clears out_valid.
`default_nettype none

module extended_gcd_bezout_unit import egb_pkg::*; #(
  parameter int OPERAND_BITS = OPERAND_BITS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [OPERAND_BITS-1:0]       first_operand,
  input  wire logic [OPERAND_BITS-1:0]       second_operand,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [DIVISOR_BITS-1:0]            divisor,
  output logic signed [COEF_BITS-1:0]        coef_first,
  output logic signed [COEF_BITS-1:0]        coef_second
);

  localparam int COUNT_BITS = $clog2(OPERAND_BITS);

  pc_t                     pc;
  pc_t                     pc_next;
  ucode_t                  uc;
  logic                    cond_hit;

  logic [OPERAND_BITS-1:0] r_prev;
  logic [OPERAND_BITS-1:0] r_cur;
  logic [OPERAND_BITS-1:0] rem;
  logic [OPERAND_BITS-1:0] quo;
  logic [COEF_BITS-1:0]    s_prev;
  logic [COEF_BITS-1:0]    s_cur;
  logic [COEF_BITS-1:0]    t_prev;
  logic [COEF_BITS-1:0]    t_cur;
  logic [COEF_BITS-1:0]    ps;
  logic [COEF_BITS-1:0]    pt;
  logic [COUNT_BITS-1:0]   count;

  logic [OPERAND_BITS:0]   trial;
  logic [OPERAND_BITS:0]   diff;
  logic                    fits;
  logic [OPERAND_BITS-1:0] rem_next;
  logic [COEF_BITS-1:0]    ps_next;
  logic [COEF_BITS-1:0]    pt_next;

  assign uc = ucode_rom(pc);

  always_comb begin
    case (uc.cond)
      COND_NEVER:    cond_hit = 1'b0;
      COND_ALWAYS:   cond_hit = 1'b1;
      COND_NO_INPUT: cond_hit = !in_valid;
      COND_REM_ZERO: cond_hit = (r_cur == '0);
      COND_COUNT_NZ: cond_hit = (count != '0);
      COND_OUT_BUSY: cond_hit = out_valid && out_stall;
      default:       cond_hit = 1'b1;
    endcase
    pc_next = cond_hit ? uc.target : pc + pc_t'(1);
  end

  assign in_stall = (pc != STEP_IDLE);

  // One restoring division step: shift in the next dividend bit and try to subtract.
  always_comb begin
    trial    = {rem, quo[OPERAND_BITS-1]};
    diff     = trial - {1'b0, r_cur};
    fits     = (trial >= {1'b0, r_cur});
    rem_next = fits ? diff[OPERAND_BITS-1:0] : trial[OPERAND_BITS-1:0];
    ps_next  = {ps[COEF_BITS-2:0], 1'b0} + (fits ? s_cur : '0);
    pt_next  = {pt[COEF_BITS-2:0], 1'b0} + (fits ? t_cur : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= STEP_IDLE;
      out_valid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (uc.op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (uc.op)
      OP_LOAD: begin
        if (!cond_hit) begin
          r_prev <= first_operand;
          r_cur  <= second_operand;
          s_prev <= COEF_BITS'(1);
          s_cur  <= '0;
          t_prev <= '0;
          t_cur  <= COEF_BITS'(1);
        end
      end
      OP_DIV_INIT: begin
        rem   <= '0;
        quo   <= r_prev;
        ps    <= '0;
        pt    <= '0;
        count <= COUNT_BITS'(OPERAND_BITS - 1);
      end
      OP_DIV_STEP: begin
        rem   <= rem_next;
        quo   <= {quo[OPERAND_BITS-2:0], fits};
        ps    <= ps_next;
        pt    <= pt_next;
        count <= count - COUNT_BITS'(1);
      end
      OP_UPDATE: begin
        r_prev <= r_cur;
        r_cur  <= rem;
        s_prev <= s_cur;
        s_cur  <= s_prev - ps;
        t_prev <= t_cur;
        t_cur  <= t_prev - pt;
      end
      OP_EMIT: begin
        divisor     <= DIVISOR_BITS'(r_prev);
        coef_first  <= s_prev;
        coef_second <= t_prev;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/egb_checker.sv =====
`default_nettype none
`include "extended_gcd_bezout_unit_assert.svh"

module egb_checker import egb_pkg::*; #(
  parameter int OPERAND_BITS = OPERAND_BITS_DEFAULT
) (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     in_valid,
  input wire logic                     in_stall,
  input wire logic [OPERAND_BITS-1:0]  first_operand,
  input wire logic [OPERAND_BITS-1:0]  second_operand,
  input wire logic                     out_valid,
  input wire logic                     out_stall,
  input wire logic [DIVISOR_BITS-1:0]  divisor,
  input wire logic [COEF_BITS-1:0]     coef_first,
  input wire logic [COEF_BITS-1:0]     coef_second
);

  logic in_xfer;
  logic in_held;
  logic out_held;

  assign in_xfer  = in_valid && !in_stall;
  assign in_held  = in_valid && in_stall;
  assign out_held = out_valid && out_stall;

  `EGB_ASSERT_NXT(a_busy_after_transfer, clk, rst, in_xfer, in_stall)
  `EGB_ASSERT_NXT(a_idle_stays_idle, clk, rst, !in_stall && !in_valid, !in_stall)
  `EGB_ASSERT_NXT(a_held_input_stable, clk, rst, in_held,
    in_valid && $stable(first_operand) && $stable(second_operand))
  `EGB_ASSERT_NXT(a_held_result_stable, clk, rst, out_held,
    out_valid && $stable(divisor) && $stable(coef_first) && $stable(coef_second))
  `EGB_ASSERT_IMP(a_reset_clears_output, clk, 1'b0, $past(rst), !out_valid)

endmodule

bind extended_gcd_bezout_unit egb_checker #(.OPERAND_BITS(OPERAND_BITS)) u_egb_checker (.*);

`default_nettype wire
